// ===== hdl/sequence_loss_window_tracker_unit_macros.svh =====
// assertion macros for the sequence loss window tracker
// expects i_clk and i_rst_n in the including module
`ifndef SEQUENCE_LOSS_WINDOW_TRACKER_UNIT_MACROS_SVH
`define SEQUENCE_LOSS_WINDOW_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define SLWT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slwt assertion failed");

// next-cycle implication
`define SLWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slwt assertion failed");

`endif

// ===== hdl/slwt_pkg.sv =====
// shared constants, types and codes for the sequence loss window tracker
// no dependencies
`timescale 1ns / 1ps

package slwt_pkg;

    localparam int WINDOW = 64;
    localparam int POS_W  = $clog2(WINDOW);

    localparam int SN_W     = 8;
    localparam int STEP_W   = 9;
    localparam int POS_R_W  = 8;
    localparam int STATUS_W = 2;
    localparam int LOST_W   = 7;
    localparam int TOTAL_W  = 32;
    localparam int OUT_W    = 48;

    localparam logic [STATUS_W-1:0] STATUS_FIRST    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OLD      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RECORDED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             init;
        logic             shift;
        logic             mark;
        logic [POS_W-1:0] idx;
    } t_win_cmd;

endpackage

// ===== hdl/sequence_loss_window_tracker_unit.sv =====
// sequence loss window tracker: unwraps serial numbers, slides the window slot by slot
// depends on slwt_pkg, slwt_window and sequence_loss_window_tracker_unit_macros.svh
// first or old numbers go from request to result without a slide; recorded ones first slide
// the window by n slots (0..127), then mark their slot in the bitmap
// no new request is taken until the result of the last one is loaded into the output register
// reset: synchronous active low, clears window, running total and output valid
`timescale 1ns / 1ps
`include "sequence_loss_window_tracker_unit_macros.svh"

module sequence_loss_window_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // serial_number[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // status[1:0], lost_now[8:2], lost_total[40:9]
);

    slwt_pkg::t_state   r_state, n_state;
    slwt_pkg::t_win_cmd w_cmd;

    logic                         r_started, n_started;
    logic [slwt_pkg::SN_W-1:0]    r_hs_lo, n_hs_lo;
    logic [slwt_pkg::POS_W-1:0]   r_rel, n_rel;
    logic [slwt_pkg::POS_R_W-1:0] r_pos, n_pos;
    logic                         r_adv, n_adv;
    logic [slwt_pkg::LOST_W-1:0]  r_lost, n_lost;
    logic [slwt_pkg::STATUS_W-1:0] r_status, n_status;
    logic [slwt_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                         r_out_valid, n_out_valid;
    logic [slwt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [slwt_pkg::LOST_W-1:0]  r_out_lost, n_out_lost;

    logic                          w_accept;
    logic                          w_load_out;
    logic                          w_beyond;
    logic                          w_lsb;
    logic [slwt_pkg::SN_W-1:0]     w_diff;
    logic signed [slwt_pkg::STEP_W-1:0] w_r;
    logic [slwt_pkg::TOTAL_W:0]    w_sum;

    assign w_diff   = i_s_axis_tdata - r_hs_lo;
    assign w_r      = $signed(slwt_pkg::STEP_W'(r_rel)) + $signed({w_diff[7], w_diff});
    assign w_beyond = r_pos >= slwt_pkg::POS_R_W'(slwt_pkg::WINDOW);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sum    = {1'b0, r_total} + (slwt_pkg::TOTAL_W + 1)'(r_lost);

    slwt_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_lsb   (w_lsb)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slwt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (r_started && !w_r[slwt_pkg::STEP_W-1]) begin
                        n_state = slwt_pkg::ST_SLIDE;
                    end else begin
                        n_state = slwt_pkg::ST_DONE;
                    end
                end
            end
            slwt_pkg::ST_SLIDE: begin
                if (!w_beyond) begin
                    n_state = slwt_pkg::ST_DONE;
                end
            end
            slwt_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = slwt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slwt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load_out      = 1'b0;
        w_cmd           = '0;
        w_cmd.idx       = r_pos[slwt_pkg::POS_W-1:0];
        case (r_state)
            slwt_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_cmd.init      = i_s_axis_tvalid && !r_started;
            end
            slwt_pkg::ST_SLIDE: begin
                w_cmd.shift = w_beyond;
                w_cmd.mark  = !w_beyond;
            end
            slwt_pkg::ST_DONE: begin
                w_load_out = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_started    = r_started;
        n_hs_lo      = r_hs_lo;
        n_rel        = r_rel;
        n_pos        = r_pos;
        n_adv        = r_adv;
        n_lost       = r_lost;
        n_status     = r_status;
        n_total      = r_total;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_lost   = r_out_lost;
        if (w_accept) begin
            n_lost = '0;
            if (!r_started) begin
                n_started = 1'b1;
                n_hs_lo   = i_s_axis_tdata;
                n_rel     = '0;
                n_status  = slwt_pkg::STATUS_FIRST;
            end else begin
                n_adv = !w_diff[7] && (w_diff != '0);
                if (n_adv) begin
                    n_hs_lo = i_s_axis_tdata;
                end
                n_pos    = w_r[slwt_pkg::POS_R_W-1:0];
                n_status = w_r[slwt_pkg::STEP_W-1] ? slwt_pkg::STATUS_OLD
                                                   : slwt_pkg::STATUS_RECORDED;
            end
        end
        if (w_cmd.shift) begin
            n_pos  = r_pos - 1'b1;
            n_lost = r_lost + slwt_pkg::LOST_W'(!w_lsb);
        end
        if (w_cmd.mark && r_adv) begin
            n_rel = r_pos[slwt_pkg::POS_W-1:0];
        end
        if (w_load_out) begin
            n_out_valid  = 1'b1;
            n_out_status = r_status;
            n_out_lost   = r_lost;
            n_total      = w_sum[slwt_pkg::TOTAL_W] ? '1 : w_sum[slwt_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slwt_pkg::ST_IDLE;
            r_started   <= 1'b0;
            r_hs_lo     <= '0;
            r_rel       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_hs_lo     <= n_hs_lo;
            r_rel       <= n_rel;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_adv        <= n_adv;
        r_lost       <= n_lost;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_lost   <= n_out_lost;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = slwt_pkg::OUT_W'({r_total, r_out_lost, r_out_status});

    `SLWT_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != slwt_pkg::ST_IDLE)
    `SLWT_ASSERT_NEXT(a_shift_counts_one, w_cmd.shift, r_lost <= $past(r_lost) + 1'b1)
    `SLWT_ASSERT_SAME(a_first_no_loss, r_out_valid && r_out_status == slwt_pkg::STATUS_FIRST,
                      r_out_lost == '0)
    `SLWT_ASSERT_SAME(a_old_no_loss, r_out_valid && r_out_status == slwt_pkg::STATUS_OLD,
                      r_out_lost == '0)
    `SLWT_ASSERT_NEXT(a_total_monotonic, r_started, r_total >= $past(r_total))

endmodule

// ===== hdl/slwt_window.sv =====
// arrival bitmap of the tracking window, one slot shifted out per cycle while a shift is commanded
// depends on slwt_pkg
`timescale 1ns / 1ps

module slwt_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slwt_pkg::t_win_cmd i_cmd,
    output logic              o_lsb
);

    logic [slwt_pkg::WINDOW-1:0] r_bitmap;
    logic [slwt_pkg::WINDOW-1:0] n_bitmap;

    always_comb begin
        n_bitmap = r_bitmap;
        if (i_cmd.init) begin
            n_bitmap = slwt_pkg::WINDOW'(1);
        end else if (i_cmd.shift) begin
            n_bitmap = r_bitmap >> 1;
        end else if (i_cmd.mark) begin
            n_bitmap[i_cmd.idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
        end else begin
            r_bitmap <= n_bitmap;
        end
    end

    assign o_lsb = r_bitmap[0];

endmodule
